// File: rtl/tfn_pkg.sv
// Shared types and constants for the triangle flat normal block.
package tfn_pkg;

   localparam int CoordW  = 32;
   localparam int EdgeW   = 33;
   localparam int ProdW   = 66;
   localparam int CrossW  = 67;
   localparam int MagW    = 66;
   localparam int HalfW   = 33;
   localparam int SqW     = 132;
   localparam int SumW    = 134;
   localparam int WideW   = 168;
   localparam int NormW   = 16;
   localparam int FracW   = 15;
   localparam int Steps   = 15;
   // seven front stages, one per result bit, one output register
   localparam int Latency = Steps + 8;
   localparam int OneQ14  = 16384;

   typedef struct packed {
      logic signed [CoordW-1:0] p0_x;
      logic signed [CoordW-1:0] p0_y;
      logic signed [CoordW-1:0] p0_z;
      logic signed [CoordW-1:0] p1_x;
      logic signed [CoordW-1:0] p1_y;
      logic signed [CoordW-1:0] p1_z;
      logic signed [CoordW-1:0] p2_x;
      logic signed [CoordW-1:0] p2_y;
      logic signed [CoordW-1:0] p2_z;
   } req_type;

   typedef struct packed {
      logic signed [NormW-1:0] normal_x;
      logic signed [NormW-1:0] normal_y;
      logic signed [NormW-1:0] normal_z;
      logic                    degenerate;
   } rsp_type;

endpackage

// File: rtl/triangle_flat_normal.sv
// Throughput: one triangle per cycle; busy is always low, no back pressure.
// Pipeline: edges, cross products, split squares, sum of squares, then one
// shift-add-compare stage per result bit (15) on all three lanes in parallel.
// Reset: synchronous, clears only the valid bits; no request is in flight after.
// Results cannot be held off: rsp_strobe marks each result for one cycle.
module triangle_flat_normal (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tfn_pkg::rsp_type rsp_data
);

   localparam int NV = 7 + tfn_pkg::Steps;

   logic [NV-1:0] vld_ff;
   logic          strobe_ff;

   // stage 1: edges
   logic signed [tfn_pkg::EdgeW-1:0] e_ff [3];
   logic signed [tfn_pkg::EdgeW-1:0] f_ff [3];
   // stage 2: the edge products, a pair for each cross product term
   logic signed [tfn_pkg::ProdW-1:0] pr_ff [6];
   // stage 3: cross product magnitude and sign
   logic [tfn_pkg::MagW-1:0] a_ff [3];
   logic [2:0]               ng3_ff;
   logic                     dg3_ff;
   // stage 4: partial squares
   logic [tfn_pkg::ProdW-1:0] hh_ff [3];
   logic [tfn_pkg::ProdW-1:0] hl_ff [3];
   logic [tfn_pkg::ProdW-1:0] ll_ff [3];
   logic [2:0]                ng4_ff;
   logic                      dg4_ff;
   // stage 5: squares
   logic [tfn_pkg::SqW-1:0] sq5_ff [3];
   logic [2:0]              ng5_ff;
   logic                    dg5_ff;
   // stage 6: squared length
   logic [tfn_pkg::SqW-1:0]  sq6_ff [3];
   logic [tfn_pkg::SumW-1:0] s6_ff;
   logic [2:0]               ng6_ff;
   logic                     dg6_ff;
   // iteration stages, index 0 is stage 7
   logic signed [tfn_pkg::WideW-1:0] r_ff [tfn_pkg::Steps+1][3];
   logic signed [tfn_pkg::WideW-1:0] q_ff [tfn_pkg::Steps+1][3];
   logic signed [tfn_pkg::WideW-1:0] s_ff [tfn_pkg::Steps+1];
   logic [tfn_pkg::FracW-1:0]        m_ff [tfn_pkg::Steps+1][3];
   logic [2:0]                       ng_ff [tfn_pkg::Steps+1];
   logic                             dg_ff [tfn_pkg::Steps+1];

   tfn_pkg::rsp_type rsp_ff;
   tfn_pkg::rsp_type rsp_in;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[NV-2:0], accept};
         strobe_ff <= vld_ff[NV-1];
      end
   end

   always_ff @(posedge clock) begin
      e_ff[0] <= tfn_pkg::EdgeW'(req_data.p1_x) - tfn_pkg::EdgeW'(req_data.p0_x);
      e_ff[1] <= tfn_pkg::EdgeW'(req_data.p1_y) - tfn_pkg::EdgeW'(req_data.p0_y);
      e_ff[2] <= tfn_pkg::EdgeW'(req_data.p1_z) - tfn_pkg::EdgeW'(req_data.p0_z);
      f_ff[0] <= tfn_pkg::EdgeW'(req_data.p2_x) - tfn_pkg::EdgeW'(req_data.p0_x);
      f_ff[1] <= tfn_pkg::EdgeW'(req_data.p2_y) - tfn_pkg::EdgeW'(req_data.p0_y);
      f_ff[2] <= tfn_pkg::EdgeW'(req_data.p2_z) - tfn_pkg::EdgeW'(req_data.p0_z);

      pr_ff[0] <= e_ff[1] * f_ff[2];
      pr_ff[1] <= e_ff[2] * f_ff[1];
      pr_ff[2] <= e_ff[2] * f_ff[0];
      pr_ff[3] <= e_ff[0] * f_ff[2];
      pr_ff[4] <= e_ff[0] * f_ff[1];
      pr_ff[5] <= e_ff[1] * f_ff[0];
   end

   logic signed [tfn_pkg::CrossW-1:0] c_w [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_w[k] = tfn_pkg::CrossW'(pr_ff[2*k]) - tfn_pkg::CrossW'(pr_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         a_ff[k]   <= c_w[k][tfn_pkg::CrossW-1] ? tfn_pkg::MagW'(-c_w[k])
                                                : tfn_pkg::MagW'(c_w[k]);
         ng3_ff[k] <= c_w[k][tfn_pkg::CrossW-1];
      end
      dg3_ff <= (c_w[0] == '0) && (c_w[1] == '0) && (c_w[2] == '0);

      // a^2 from 33-bit halves
      for (int k = 0; k < 3; k++) begin
         hh_ff[k] <= a_ff[k][tfn_pkg::MagW-1:tfn_pkg::HalfW] *
                     a_ff[k][tfn_pkg::MagW-1:tfn_pkg::HalfW];
         hl_ff[k] <= a_ff[k][tfn_pkg::MagW-1:tfn_pkg::HalfW] *
                     a_ff[k][tfn_pkg::HalfW-1:0];
         ll_ff[k] <= a_ff[k][tfn_pkg::HalfW-1:0] * a_ff[k][tfn_pkg::HalfW-1:0];
      end
      ng4_ff <= ng3_ff;
      dg4_ff <= dg3_ff;

      for (int k = 0; k < 3; k++) begin
         sq5_ff[k] <= {hh_ff[k], {tfn_pkg::ProdW{1'b0}}} +
                      (tfn_pkg::SqW'(hl_ff[k]) << (tfn_pkg::HalfW + 1)) +
                      tfn_pkg::SqW'(ll_ff[k]);
      end
      ng5_ff <= ng4_ff;
      dg5_ff <= dg4_ff;

      sq6_ff <= sq5_ff;
      s6_ff  <= tfn_pkg::SumW'(sq5_ff[0]) + tfn_pkg::SumW'(sq5_ff[1]) +
                tfn_pkg::SumW'(sq5_ff[2]);
      ng6_ff <= ng5_ff;
      dg6_ff <= dg5_ff;

      // remainder = c^2 * 2^30 - S, running product = (2m-1) * S with m = 0
      for (int k = 0; k < 3; k++) begin
         r_ff[0][k] <= $signed(tfn_pkg::WideW'(sq6_ff[k]) << 30) -
                       $signed(tfn_pkg::WideW'(s6_ff));
         q_ff[0][k] <= -$signed(tfn_pkg::WideW'(s6_ff));
         m_ff[0][k] <= '0;
      end
      s_ff[0]  <= $signed(tfn_pkg::WideW'(s6_ff));
      ng_ff[0] <= ng6_ff;
      dg_ff[0] <= dg6_ff;
   end

   for (genvar i = 0; i < tfn_pkg::Steps; i++) begin : g_step
      localparam int B = tfn_pkg::Steps - 1 - i;
      logic signed [tfn_pkg::WideW-1:0] d_w [3];
      logic                             take_w [3];

      // trying bit B: (2t-1)^2 - (2m-1)^2 = 2^(B+2) * ((2m-1) + 2^B)
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            d_w[k]    = (q_ff[i][k] + (s_ff[i] <<< B)) <<< (B + 2);
            take_w[k] = !((i != 0) && m_ff[i][k][tfn_pkg::FracW-1]) &&
                        (r_ff[i][k] >= d_w[k]);
         end
      end

      always_ff @(posedge clock) begin
         for (int k = 0; k < 3; k++) begin
            r_ff[i+1][k] <= take_w[k] ? r_ff[i][k] - d_w[k] : r_ff[i][k];
            q_ff[i+1][k] <= take_w[k] ? q_ff[i][k] + (s_ff[i] <<< (B + 1))
                                      : q_ff[i][k];
            m_ff[i+1][k] <= m_ff[i][k] | (tfn_pkg::FracW'(take_w[k]) << B);
         end
         s_ff[i+1]  <= s_ff[i];
         ng_ff[i+1] <= ng_ff[i];
         dg_ff[i+1] <= dg_ff[i];
      end
   end

   logic [tfn_pkg::NormW-1:0] n_w [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dg_ff[tfn_pkg::Steps]) begin
            n_w[k] = '0;
         end else if (ng_ff[tfn_pkg::Steps][k]) begin
            n_w[k] = tfn_pkg::NormW'(0) -
                     tfn_pkg::NormW'(m_ff[tfn_pkg::Steps][k]);
         end else begin
            n_w[k] = tfn_pkg::NormW'(m_ff[tfn_pkg::Steps][k]);
         end
      end
      rsp_in.normal_x   = $signed(n_w[0]);
      rsp_in.normal_y   = $signed(n_w[1]);
      rsp_in.normal_z   = $signed(n_w[2]);
      rsp_in.degenerate = dg_ff[tfn_pkg::Steps];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/tfn_checker.sv
// Port-level checks for the triangle flat normal block, bound to the top level.
module tfn_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tfn_pkg::req_type req_data,
   input logic             rsp_strobe,
   input tfn_pkg::rsp_type rsp_data
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, tfn_pkg::Latency))
      else $error("result without request");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.degenerate |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 &&
         rsp_data.normal_z == '0)
      else $error("degenerate result with nonzero normal");

   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.degenerate |->
         rsp_data.normal_x != '0 || rsp_data.normal_y != '0 ||
         rsp_data.normal_z != '0)
      else $error("zero normal on valid triangle");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         rsp_data.normal_x <= 16'sd16384 && rsp_data.normal_x >= -16'sd16384 &&
         rsp_data.normal_y <= 16'sd16384 && rsp_data.normal_y >= -16'sd16384 &&
         rsp_data.normal_z <= 16'sd16384 && rsp_data.normal_z >= -16'sd16384)
      else $error("normal out of range");

endmodule

bind triangle_flat_normal tfn_checker u_tfn_checker (.*);
